@@ rtl/core/lsu_pkg.sv @@
// ----------------------------------------------------------------------------
// Load/store unit package
// Shared types and constants for the load/store unit: register indexes,
// the decoded operation that moves from the front end to the back end,
// and sizing constants.
// ----------------------------------------------------------------------------
package lsu_pkg;

	localparam int ADDR_BITS_DEF = 16;
	localparam int QUEUE_DEPTH   = 2;
	localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] HIGH_PAGE = 8'hFF;

	localparam logic [2:0] IDX_B   = 3'd0;
	localparam logic [2:0] IDX_C   = 3'd1;
	localparam logic [2:0] IDX_D   = 3'd2;
	localparam logic [2:0] IDX_E   = 3'd3;
	localparam logic [2:0] IDX_H   = 3'd4;
	localparam logic [2:0] IDX_L   = 3'd5;
	localparam logic [2:0] IDX_MEM = 3'd6;
	localparam logic [2:0] IDX_A   = 3'd7;

	typedef enum logic [2:0] {
		K_NONE,
		K_SET_REG,
		K_STORE,
		K_LOAD,
		K_SET_PAIR,
		K_SET_SP
	} op_kind_t;

	typedef enum logic [2:0] {
		AS_BC,
		AS_DE,
		AS_HL,
		AS_N16,
		AS_HIGH_N8,
		AS_HIGH_C
	} addr_sel_t;

	typedef enum logic [1:0] {
		DS_A,
		DS_IMM,
		DS_REG
	} data_sel_t;

	typedef enum logic [1:0] {
		HL_KEEP,
		HL_INC,
		HL_DEC
	} hl_step_t;

	typedef struct packed {
		op_kind_t  kind;
		addr_sel_t addr_sel;
		data_sel_t data_sel;
		hl_step_t  hl_step;
		logic [2:0]  dst;
		logic [2:0]  src;
		logic [15:0] imm;
	} lsu_op_t;

endpackage

@@ rtl/core/lsu_req_if.sv @@
// ----------------------------------------------------------------------------
// Load/store request channel
// Valid/ready channel that carries one load-group instruction per request.
// ----------------------------------------------------------------------------
interface lsu_req_if;
	logic       valid;
	logic       ready;
	logic [4:0] req_type;
	logic [7:0] opcode;
	logic [7:0] imm_low;
	logic [7:0] imm_high;

	modport source (output valid, output req_type, output opcode, output imm_low,
		output imm_high, input ready);
	modport sink (input valid, input req_type, input opcode, input imm_low,
		input imm_high, output ready);
endinterface

@@ rtl/core/lsu_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Load/store result channel
// Valid/ready channel that carries the register state and memory write
// after each instruction.
// ----------------------------------------------------------------------------
interface lsu_rsp_if;
	logic        valid;
	logic        ready;
	logic [7:0]  reg_a;
	logic [7:0]  reg_b;
	logic [7:0]  reg_c;
	logic [7:0]  reg_d;
	logic [7:0]  reg_e;
	logic [7:0]  reg_h;
	logic [7:0]  reg_l;
	logic [15:0] stack_pointer;
	logic        mem_written;
	logic [15:0] mem_addr;
	logic [7:0]  mem_data;

	modport source (output valid, output reg_a, output reg_b, output reg_c,
		output reg_d, output reg_e, output reg_h, output reg_l, output stack_pointer,
		output mem_written, output mem_addr, output mem_data, input ready);
	modport sink (input valid, input reg_a, input reg_b, input reg_c,
		input reg_d, input reg_e, input reg_h, input reg_l, input stack_pointer,
		input mem_written, input mem_addr, input mem_data, output ready);
endinterface

@@ rtl/core/cpu_load_store_unit.sv @@
// ----------------------------------------------------------------------------
// CPU load/store unit
// Executes the load group of an 8-bit CPU, one instruction per request,
// and reports the registers and any memory write after each one.
// ----------------------------------------------------------------------------
//  channel  direction  handshake    payload
//  req      in         valid/ready  req_type, opcode, imm_low, imm_high
//  rsp      out        valid/ready  reg_a..reg_l, stack_pointer, mem_written,
//                                   mem_addr, mem_data
//
// A load reads memory in ST_RUN and writes its register in ST_LOAD; every
// other form completes in ST_RUN. The front-end register and the queue add
// latency only. After reset the data memory is cleared one byte per cycle,
// all 2**ADDR_BITS bytes, during which requests collect in the front end
// and queue. A stalled result holds the back end; the front end keeps
// taking requests until the queue and its own register are full.
module cpu_load_store_unit #(
	parameter int ADDR_BITS = lsu_pkg::ADDR_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	lsu_req_if.sink    req,
	lsu_rsp_if.source  rsp
);

	logic             fq_valid;
	logic             fq_ready;
	lsu_pkg::lsu_op_t fq_op;
	logic             qb_valid;
	logic             qb_ready;
	lsu_pkg::lsu_op_t qb_op;

	lsu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_op    (fq_op)
	);

	lsu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_op    (fq_op),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_op     (qb_op)
	);

	lsu_back #(
		.ADDR_BITS (ADDR_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (qb_valid),
		.pop_ready (qb_ready),
		.pop_op    (qb_op),
		.rsp       (rsp)
	);

endmodule

@@ rtl/core/lsu_front.sv @@
// ----------------------------------------------------------------------------
// Load/store front end
// Accepts requests and decodes the load form into an operation for the
// back end, held in one register stage.
// ----------------------------------------------------------------------------
module lsu_front (
	input  logic              clk,
	input  logic              arst_n,
	lsu_req_if.sink           req,
	output logic              push_valid,
	input  logic              push_ready,
	output lsu_pkg::lsu_op_t  push_op
);

	localparam logic [4:0] F_R_N8       = 5'd0;
	localparam logic [4:0] F_R_R        = 5'd1;
	localparam logic [4:0] F_ST_BC      = 5'd2;
	localparam logic [4:0] F_ST_DE      = 5'd3;
	localparam logic [4:0] F_LD_BC      = 5'd4;
	localparam logic [4:0] F_LD_DE      = 5'd5;
	localparam logic [4:0] F_ST_HLI     = 5'd6;
	localparam logic [4:0] F_ST_HLD     = 5'd7;
	localparam logic [4:0] F_LD_HLI     = 5'd8;
	localparam logic [4:0] F_LD_HLD     = 5'd9;
	localparam logic [4:0] F_BC_N16     = 5'd10;
	localparam logic [4:0] F_DE_N16     = 5'd11;
	localparam logic [4:0] F_ST_HL_N8   = 5'd12;
	localparam logic [4:0] F_SP_N16     = 5'd13;
	localparam logic [4:0] F_ST_ABS     = 5'd14;
	localparam logic [4:0] F_LD_ABS     = 5'd15;
	localparam logic [4:0] F_ST_HIGH_N8 = 5'd16;
	localparam logic [4:0] F_LD_HIGH_N8 = 5'd17;
	localparam logic [4:0] F_ST_HIGH_C  = 5'd18;
	localparam logic [4:0] F_LD_HIGH_C  = 5'd19;

	lsu_pkg::lsu_op_t dec;
	lsu_pkg::lsu_op_t op_s1;
	logic             valid_s1;
	logic [2:0]       dst;
	logic [2:0]       src;

	assign dst = req.opcode[5:3];
	assign src = req.opcode[2:0];

	always_comb begin
		dec          = '0;
		dec.kind     = lsu_pkg::K_NONE;
		dec.addr_sel = lsu_pkg::AS_HL;
		dec.data_sel = lsu_pkg::DS_A;
		dec.hl_step  = lsu_pkg::HL_KEEP;
		dec.dst      = lsu_pkg::IDX_A;
		dec.src      = src;
		dec.imm      = {req.imm_high, req.imm_low};
		case (req.req_type)
			F_R_N8: begin
				dec.data_sel = lsu_pkg::DS_IMM;
				if (dst == lsu_pkg::IDX_MEM) begin
					dec.kind = lsu_pkg::K_STORE;
				end else begin
					dec.kind = lsu_pkg::K_SET_REG;
					dec.dst  = dst;
				end
			end
			F_R_R: begin
				dec.data_sel = lsu_pkg::DS_REG;
				dec.dst      = dst;
				if (dst == lsu_pkg::IDX_MEM && src == lsu_pkg::IDX_MEM) begin
					dec.kind = lsu_pkg::K_NONE;
				end else if (dst == lsu_pkg::IDX_MEM) begin
					dec.kind = lsu_pkg::K_STORE;
				end else if (src == lsu_pkg::IDX_MEM) begin
					dec.kind = lsu_pkg::K_LOAD;
				end else begin
					dec.kind = lsu_pkg::K_SET_REG;
				end
			end
			F_ST_BC: begin
				dec.kind     = lsu_pkg::K_STORE;
				dec.addr_sel = lsu_pkg::AS_BC;
			end
			F_ST_DE: begin
				dec.kind     = lsu_pkg::K_STORE;
				dec.addr_sel = lsu_pkg::AS_DE;
			end
			F_LD_BC: begin
				dec.kind     = lsu_pkg::K_LOAD;
				dec.addr_sel = lsu_pkg::AS_BC;
			end
			F_LD_DE: begin
				dec.kind     = lsu_pkg::K_LOAD;
				dec.addr_sel = lsu_pkg::AS_DE;
			end
			F_ST_HLI: begin
				dec.kind    = lsu_pkg::K_STORE;
				dec.hl_step = lsu_pkg::HL_INC;
			end
			F_ST_HLD: begin
				dec.kind    = lsu_pkg::K_STORE;
				dec.hl_step = lsu_pkg::HL_DEC;
			end
			F_LD_HLI: begin
				dec.kind    = lsu_pkg::K_LOAD;
				dec.hl_step = lsu_pkg::HL_INC;
			end
			F_LD_HLD: begin
				dec.kind    = lsu_pkg::K_LOAD;
				dec.hl_step = lsu_pkg::HL_DEC;
			end
			F_BC_N16: begin
				dec.kind = lsu_pkg::K_SET_PAIR;
				dec.dst  = lsu_pkg::IDX_B;
			end
			F_DE_N16: begin
				dec.kind = lsu_pkg::K_SET_PAIR;
				dec.dst  = lsu_pkg::IDX_D;
			end
			F_ST_HL_N8: begin
				dec.kind     = lsu_pkg::K_STORE;
				dec.data_sel = lsu_pkg::DS_IMM;
			end
			F_SP_N16: begin
				dec.kind = lsu_pkg::K_SET_SP;
			end
			F_ST_ABS: begin
				dec.kind     = lsu_pkg::K_STORE;
				dec.addr_sel = lsu_pkg::AS_N16;
			end
			F_LD_ABS: begin
				dec.kind     = lsu_pkg::K_LOAD;
				dec.addr_sel = lsu_pkg::AS_N16;
			end
			F_ST_HIGH_N8: begin
				dec.kind     = lsu_pkg::K_STORE;
				dec.addr_sel = lsu_pkg::AS_HIGH_N8;
			end
			F_LD_HIGH_N8: begin
				dec.kind     = lsu_pkg::K_LOAD;
				dec.addr_sel = lsu_pkg::AS_HIGH_N8;
			end
			F_ST_HIGH_C: begin
				dec.kind     = lsu_pkg::K_STORE;
				dec.addr_sel = lsu_pkg::AS_HIGH_C;
			end
			F_LD_HIGH_C: begin
				dec.kind     = lsu_pkg::K_LOAD;
				dec.addr_sel = lsu_pkg::AS_HIGH_C;
			end
			default: begin
				dec.kind = lsu_pkg::K_NONE;
			end
		endcase
	end

	assign req.ready  = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_op    = op_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			op_s1 <= dec;
		end
	end

endmodule

@@ rtl/core/lsu_queue.sv @@
// ----------------------------------------------------------------------------
// Load/store operation queue
// Short FIFO of decoded operations between the front end and the back end.
// ----------------------------------------------------------------------------
module lsu_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  lsu_pkg::lsu_op_t  push_op,
	output logic              pop_valid,
	input  logic              pop_ready,
	output lsu_pkg::lsu_op_t  pop_op
);

	lsu_pkg::lsu_op_t              entry_q [lsu_pkg::QUEUE_DEPTH];
	logic [lsu_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [lsu_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [lsu_pkg::QCNT_W-1:0]    count_q;
	logic                          push;
	logic                          pop;

	assign push_ready = count_q != lsu_pkg::QCNT_W'(lsu_pkg::QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_op     = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == lsu_pkg::QPTR_W'(lsu_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == lsu_pkg::QPTR_W'(lsu_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

@@ rtl/core/lsu_back.sv @@
// ----------------------------------------------------------------------------
// Load/store back end
// Holds the register file, the stack pointer and the data memory, carries
// out one decoded operation at a time and presents the result.
// ----------------------------------------------------------------------------
module lsu_back #(
	parameter int ADDR_BITS = lsu_pkg::ADDR_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pop_valid,
	output logic              pop_ready,
	input  lsu_pkg::lsu_op_t  pop_op,
	lsu_rsp_if.source         rsp
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_RUN,
		ST_LOAD
	} state_t;

	state_t               state_q;
	logic [ADDR_BITS-1:0] clr_q;
	logic [7:0]           regs_q [8];
	logic [15:0]          sp_q;
	logic                 rsp_valid_q;
	logic                 wr_q;
	logic [15:0]          waddr_q;
	logic [7:0]           wdata_q;
	logic [2:0]           ld_dst_q;
	logic [7:0]           mem_q [2**ADDR_BITS];
	logic [7:0]           rdata_q;

	logic [15:0]          hl;
	logic [15:0]          hl_next;
	logic [15:0]          addr;
	logic [7:0]           data;
	logic [2:0]           pair_lo;
	logic                 fire;
	logic                 mem_we;
	logic [ADDR_BITS-1:0] mem_waddr;
	logic [7:0]           mem_wdata;

	assign hl      = {regs_q[lsu_pkg::IDX_H], regs_q[lsu_pkg::IDX_L]};
	assign pair_lo = {pop_op.dst[2:1], 1'b1};

	always_comb begin
		case (pop_op.hl_step)
			lsu_pkg::HL_INC: hl_next = hl + 16'd1;
			lsu_pkg::HL_DEC: hl_next = hl - 16'd1;
			default:         hl_next = hl;
		endcase
	end

	always_comb begin
		case (pop_op.addr_sel)
			lsu_pkg::AS_BC:      addr = {regs_q[lsu_pkg::IDX_B], regs_q[lsu_pkg::IDX_C]};
			lsu_pkg::AS_DE:      addr = {regs_q[lsu_pkg::IDX_D], regs_q[lsu_pkg::IDX_E]};
			lsu_pkg::AS_N16:     addr = pop_op.imm;
			lsu_pkg::AS_HIGH_N8: addr = {lsu_pkg::HIGH_PAGE, pop_op.imm[7:0]};
			lsu_pkg::AS_HIGH_C:  addr = {lsu_pkg::HIGH_PAGE, regs_q[lsu_pkg::IDX_C]};
			default:             addr = hl;
		endcase
	end

	always_comb begin
		case (pop_op.data_sel)
			lsu_pkg::DS_IMM: data = pop_op.imm[7:0];
			lsu_pkg::DS_REG: data = regs_q[pop_op.src];
			default:         data = regs_q[lsu_pkg::IDX_A];
		endcase
	end

	assign pop_ready = (state_q == ST_RUN) && (!rsp_valid_q || rsp.ready);
	assign fire      = pop_ready && pop_valid;
	assign mem_we    = (state_q == ST_CLEAR) || (fire && pop_op.kind == lsu_pkg::K_STORE);
	assign mem_waddr = (state_q == ST_CLEAR) ? clr_q : addr[ADDR_BITS-1:0];
	assign mem_wdata = (state_q == ST_CLEAR) ? 8'd0 : data;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem_q[addr[ADDR_BITS-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			regs_q      <= '{default: 8'd0};
			sp_q        <= '0;
			rsp_valid_q <= 1'b0;
			wr_q        <= 1'b0;
			waddr_q     <= '0;
			wdata_q     <= '0;
			ld_dst_q    <= lsu_pkg::IDX_A;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (rsp_valid_q && rsp.ready) begin
						rsp_valid_q <= 1'b0;
					end
					if (fire) begin
						ld_dst_q <= pop_op.dst;
						wr_q     <= pop_op.kind == lsu_pkg::K_STORE;
						waddr_q  <= (pop_op.kind == lsu_pkg::K_STORE) ? addr : 16'd0;
						wdata_q  <= (pop_op.kind == lsu_pkg::K_STORE) ? data : 8'd0;
						case (pop_op.kind)
							lsu_pkg::K_SET_REG: begin
								regs_q[pop_op.dst] <= data;
							end
							lsu_pkg::K_SET_PAIR: begin
								regs_q[pop_op.dst] <= pop_op.imm[15:8];
								regs_q[pair_lo]    <= pop_op.imm[7:0];
							end
							lsu_pkg::K_SET_SP: begin
								sp_q <= pop_op.imm;
							end
							lsu_pkg::K_STORE, lsu_pkg::K_LOAD: begin
								regs_q[lsu_pkg::IDX_H] <= hl_next[15:8];
								regs_q[lsu_pkg::IDX_L] <= hl_next[7:0];
							end
							default: begin
							end
						endcase
						if (pop_op.kind == lsu_pkg::K_LOAD) begin
							state_q <= ST_LOAD;
						end else begin
							rsp_valid_q <= 1'b1;
						end
					end
				end
				ST_LOAD: begin
					regs_q[ld_dst_q] <= rdata_q;
					rsp_valid_q      <= 1'b1;
					state_q          <= ST_RUN;
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.reg_a         = regs_q[lsu_pkg::IDX_A];
	assign rsp.reg_b         = regs_q[lsu_pkg::IDX_B];
	assign rsp.reg_c         = regs_q[lsu_pkg::IDX_C];
	assign rsp.reg_d         = regs_q[lsu_pkg::IDX_D];
	assign rsp.reg_e         = regs_q[lsu_pkg::IDX_E];
	assign rsp.reg_h         = regs_q[lsu_pkg::IDX_H];
	assign rsp.reg_l         = regs_q[lsu_pkg::IDX_L];
	assign rsp.stack_pointer = sp_q;
	assign rsp.mem_written   = wr_q;
	assign rsp.mem_addr      = waddr_q;
	assign rsp.mem_data      = wdata_q;

endmodule

@@ tb/sv/lsu_form_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Load form codes
// Codes of the twenty load forms that the load/store unit executes, shared by
// the stimulus and the checker. Codes from FORM_COUNT upward are unused.
// ----------------------------------------------------------------------------
package lsu_form_pkg;

	typedef enum logic [4:0] {
		F_LD_R_N8,
		F_LD_R_R,
		F_ST_BC,
		F_ST_DE,
		F_LD_A_BC,
		F_LD_A_DE,
		F_ST_HLI,
		F_ST_HLD,
		F_LD_A_HLI,
		F_LD_A_HLD,
		F_LD_BC_N16,
		F_LD_DE_N16,
		F_ST_HL_N8,
		F_LD_SP_N16,
		F_ST_N16,
		F_LD_A_N16,
		F_STH_N8,
		F_LDH_N8,
		F_STH_C,
		F_LDH_C
	} load_form_t;

	localparam int         FORM_COUNT    = 20;
	localparam logic [4:0] FORM_CODE_MAX = 5'h1F;

endpackage

@@ tb/sv/load_store_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Load/store unit checker
// Watches the request and result channels. Every accepted request is run
// through a local model of the register file, stack pointer and data memory,
// and the resulting register and write report is queued. Every accepted
// result is compared field by field against the oldest queued report.
// ----------------------------------------------------------------------------
module load_store_checker #(
	parameter int ADDR_BITS = lsu_pkg::ADDR_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	lsu_req_if   req,
	lsu_rsp_if   rsp,
	output int   errors,
	output int   pending
);
	import lsu_pkg::*;
	import lsu_form_pkg::*;

	localparam logic [15:0] ADDR_MASK = 16'((32'd1 << ADDR_BITS) - 1);

	typedef struct packed {
		logic [7:0]  a;
		logic [7:0]  b;
		logic [7:0]  c;
		logic [7:0]  d;
		logic [7:0]  e;
		logic [7:0]  h;
		logic [7:0]  l;
		logic [15:0] sp;
		logic        wr;
		logic [15:0] addr;
		logic [7:0]  data;
	} cpu_view_t;

	logic [7:0]  gpr [8];
	logic [15:0] sp_val;
	logic [7:0]  ram [65536];
	cpu_view_t   view_q [$];
	int          reported;

	function automatic logic [15:0] pair(logic [2:0] hi, logic [2:0] lo);
		return {gpr[hi], gpr[lo]};
	endfunction

	function automatic logic [7:0] peek(logic [15:0] addr);
		return ram[addr & ADDR_MASK];
	endfunction

	task automatic set_pair(input logic [2:0] hi, input logic [2:0] lo, input logic [15:0] val);
		gpr[hi] = val[15:8];
		gpr[lo] = val[7:0];
	endtask

	task automatic run_load(input logic [4:0] form, input logic [7:0] op,
		input logic [7:0] lo, input logic [7:0] hi, output cpu_view_t v);
		logic [2:0]  dst;
		logic [2:0]  src;
		logic [15:0] hl;
		logic [15:0] n16;
		logic [7:0]  acc;
		logic        wr;
		logic [15:0] wa;
		logic [7:0]  wd;
		dst = op[5:3];
		src = op[2:0];
		hl  = pair(IDX_H, IDX_L);
		n16 = {hi, lo};
		acc = gpr[IDX_A];
		wr  = 1'b0;
		wa  = 16'h0;
		wd  = 8'h0;
		case (form)
			F_LD_R_N8: begin
				if (dst == IDX_MEM) begin
					wr = 1'b1; wa = hl; wd = lo;
				end else begin
					gpr[dst] = lo;
				end
			end
			F_LD_R_R: begin
				if (dst == IDX_MEM && src != IDX_MEM) begin
					wr = 1'b1; wa = hl; wd = gpr[src];
				end else if (src == IDX_MEM && dst != IDX_MEM) begin
					gpr[dst] = peek(hl);
				end else if (dst != IDX_MEM) begin
					gpr[dst] = gpr[src];
				end
			end
			F_ST_BC: begin wr = 1'b1; wa = pair(IDX_B, IDX_C); wd = acc; end
			F_ST_DE: begin wr = 1'b1; wa = pair(IDX_D, IDX_E); wd = acc; end
			F_LD_A_BC: gpr[IDX_A] = peek(pair(IDX_B, IDX_C));
			F_LD_A_DE: gpr[IDX_A] = peek(pair(IDX_D, IDX_E));
			F_ST_HLI: begin
				wr = 1'b1; wa = hl; wd = acc;
				set_pair(IDX_H, IDX_L, hl + 16'd1);
			end
			F_ST_HLD: begin
				wr = 1'b1; wa = hl; wd = acc;
				set_pair(IDX_H, IDX_L, hl - 16'd1);
			end
			F_LD_A_HLI: begin
				gpr[IDX_A] = peek(hl);
				set_pair(IDX_H, IDX_L, hl + 16'd1);
			end
			F_LD_A_HLD: begin
				gpr[IDX_A] = peek(hl);
				set_pair(IDX_H, IDX_L, hl - 16'd1);
			end
			F_LD_BC_N16: set_pair(IDX_B, IDX_C, n16);
			F_LD_DE_N16: set_pair(IDX_D, IDX_E, n16);
			F_ST_HL_N8: begin wr = 1'b1; wa = hl; wd = lo; end
			F_LD_SP_N16: sp_val = n16;
			F_ST_N16: begin wr = 1'b1; wa = n16; wd = acc; end
			F_LD_A_N16: gpr[IDX_A] = peek(n16);
			F_STH_N8: begin wr = 1'b1; wa = {HIGH_PAGE, lo}; wd = acc; end
			F_LDH_N8: gpr[IDX_A] = peek({HIGH_PAGE, lo});
			F_STH_C: begin wr = 1'b1; wa = {HIGH_PAGE, gpr[IDX_C]}; wd = acc; end
			F_LDH_C: gpr[IDX_A] = peek({HIGH_PAGE, gpr[IDX_C]});
			default: ;
		endcase
		if (wr) begin
			ram[wa & ADDR_MASK] = wd;
		end
		v.a    = gpr[IDX_A];
		v.b    = gpr[IDX_B];
		v.c    = gpr[IDX_C];
		v.d    = gpr[IDX_D];
		v.e    = gpr[IDX_E];
		v.h    = gpr[IDX_H];
		v.l    = gpr[IDX_L];
		v.sp   = sp_val;
		v.wr   = wr;
		v.addr = wa;
		v.data = wd;
	endtask

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (want !== got) begin
			errors++;
			if (reported < 10) begin
				reported++;
				$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		cpu_view_t v;
		cpu_view_t want;
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) gpr[i] = 8'h0;
			for (int i = 0; i < 65536; i++) ram[i] = 8'h0;
			sp_val = 16'h0;
			view_q.delete();
			errors   = 0;
			pending  = 0;
			reported = 0;
		end else begin
			if (req.valid && req.ready) begin
				run_load(req.req_type, req.opcode, req.imm_low, req.imm_high, v);
				view_q.push_back(v);
			end
			if (rsp.valid && rsp.ready) begin
				if (view_q.size() == 0) begin
					errors++;
					if (reported < 10) begin
						reported++;
						$display("%0t: unexpected result, a=%h hl=%h%h sp=%h write=%b", $time,
							rsp.reg_a, rsp.reg_h, rsp.reg_l, rsp.stack_pointer, rsp.mem_written);
					end
				end else begin
					want = view_q.pop_front();
					check_field("reg_a", 16'(want.a), 16'(rsp.reg_a));
					check_field("reg_b", 16'(want.b), 16'(rsp.reg_b));
					check_field("reg_c", 16'(want.c), 16'(rsp.reg_c));
					check_field("reg_d", 16'(want.d), 16'(rsp.reg_d));
					check_field("reg_e", 16'(want.e), 16'(rsp.reg_e));
					check_field("reg_h", 16'(want.h), 16'(rsp.reg_h));
					check_field("reg_l", 16'(want.l), 16'(rsp.reg_l));
					check_field("stack_pointer", want.sp, rsp.stack_pointer);
					check_field("mem_written", 16'(want.wr), 16'(rsp.mem_written));
					check_field("mem_addr", want.addr, rsp.mem_addr);
					check_field("mem_data", 16'(want.data), 16'(rsp.mem_data));
				end
			end
			pending = view_q.size();
		end
	end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Load/store unit testbench
// Drives a directed pass over every load form and its corner cases, then
// random instruction streams whose addresses mostly come from a small pool
// so that loads read back earlier stores. Both channels idle at random and
// the result side holds off once for a long stretch to fill the unit.
// ----------------------------------------------------------------------------
module tb;
	import lsu_pkg::*;
	import lsu_form_pkg::*;

	localparam int STALL_LIMIT  = 200000;
	localparam int RANDOM_LOADS = 1520;
	localparam int HOLD_AFTER   = 300;
	localparam int LONG_HOLD    = 400;
	localparam int DRAIN_CYCLES = 16;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	int   results_seen = 0;
	int   idle_cycles  = 0;
	bit   steady       = 1'b0;

	logic [15:0] addr_pool [8] = '{16'h0000, 16'hFFFF, 16'hFF00, 16'hFF07,
		16'hC000, 16'h8001, 16'h0100, 16'h7FFE};

	lsu_req_if req_ch ();
	lsu_rsp_if rsp_ch ();

	cpu_load_store_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	load_store_checker u_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.errors  (errors),
		.pending (pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) results_seen <= results_seen + 1;
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("tb: errors");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	function automatic int idle_len(bit calm);
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 94) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] ld_op(logic [2:0] dst, logic [2:0] src);
		return {2'b01, dst, src};
	endfunction

	task automatic offer_load(input logic [4:0] form, input logic [7:0] op,
		input logic [7:0] lo, input logic [7:0] hi);
		int gap;
		gap = idle_len(steady);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.req_type <= form;
		req_ch.opcode   <= op;
		req_ch.imm_low  <= lo;
		req_ch.imm_high <= hi;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic random_load();
		logic [4:0]  form;
		logic [7:0]  op;
		logic [7:0]  lo;
		logic [7:0]  hi;
		logic [15:0] a;
		a  = addr_pool[$urandom_range(0, 7)] + 16'($urandom_range(0, 3));
		op = 8'($urandom);
		lo = a[7:0];
		hi = a[15:8];
		if ($urandom_range(0, 99) < 8) begin
			form = 5'($urandom);
			lo   = 8'($urandom);
			hi   = 8'($urandom);
		end else begin
			form = 5'($urandom_range(0, FORM_COUNT - 1));
			case (form)
				F_LD_R_N8: begin
					if (op[5:3] == IDX_H) lo = a[15:8];
					else if (op[5:3] != IDX_L && $urandom_range(0, 1)) lo = 8'($urandom);
				end
				F_ST_HL_N8: lo = 8'($urandom);
				F_STH_N8, F_LDH_N8: lo = 8'($urandom_range(0, 11));
				default: ;
			endcase
		end
		offer_load(form, op, lo, hi);
	endtask

	initial begin
		arst_n          = 1'b0;
		req_ch.valid    = 1'b0;
		req_ch.req_type = 5'h0;
		req_ch.opcode   = 8'h0;
		req_ch.imm_low  = 8'h0;
		req_ch.imm_high = 8'h0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		offer_load(F_LD_R_N8, ld_op(IDX_A, IDX_B), 8'h5A, 8'hFF);
		offer_load(F_LD_R_N8, ld_op(IDX_H, IDX_A), 8'hFF, 8'h00);
		offer_load(F_LD_R_N8, {2'b11, IDX_L, IDX_MEM}, 8'hFF, 8'h00);
		offer_load(F_ST_HLI, 8'hFF, 8'h00, 8'h00);
		offer_load(F_ST_HLD, 8'h00, 8'hFF, 8'hFF);
		offer_load(F_LD_A_HLI, 8'h00, 8'h00, 8'h00);
		offer_load(F_LD_A_HLD, 8'hFF, 8'h00, 8'h00);
		offer_load(F_LD_BC_N16, 8'h00, 8'h34, 8'h12);
		offer_load(F_LD_DE_N16, 8'h00, 8'hFF, 8'hFF);
		offer_load(F_ST_BC, 8'h00, 8'h00, 8'h00);
		offer_load(F_ST_DE, 8'h00, 8'h00, 8'h00);
		offer_load(F_LD_R_N8, ld_op(IDX_A, IDX_A), 8'h00, 8'h00);
		offer_load(F_LD_A_BC, 8'h00, 8'h00, 8'h00);
		offer_load(F_LD_A_DE, 8'h00, 8'h00, 8'h00);
		offer_load(F_ST_HL_N8, 8'h00, 8'h00, 8'hFF);
		offer_load(F_LD_SP_N16, 8'h00, 8'hFF, 8'hFF);
		offer_load(F_ST_N16, 8'h00, 8'h00, 8'h80);
		offer_load(F_LD_A_N16, 8'h00, 8'h00, 8'h80);
		offer_load(F_STH_N8, 8'h00, 8'hFF, 8'h00);
		offer_load(F_LDH_N8, 8'h00, 8'hFF, 8'h00);
		offer_load(F_LD_R_N8, ld_op(IDX_C, IDX_B), 8'h80, 8'h00);
		offer_load(F_STH_C, 8'h00, 8'h00, 8'h00);
		offer_load(F_LDH_C, 8'h00, 8'h00, 8'h00);
		offer_load(F_LD_R_N8, ld_op(IDX_MEM, IDX_B), 8'hA5, 8'h00);
		offer_load(F_LD_R_R, ld_op(IDX_MEM, IDX_MEM), 8'h00, 8'h00);
		offer_load(F_LD_R_R, ld_op(IDX_MEM, IDX_B), 8'h00, 8'h00);
		offer_load(F_LD_R_R, ld_op(IDX_D, IDX_MEM), 8'h00, 8'h00);
		offer_load(F_LD_R_R, ld_op(IDX_E, IDX_A), 8'h00, 8'h00);
		offer_load(5'(FORM_COUNT), 8'hFF, 8'hFF, 8'hFF);
		offer_load(FORM_CODE_MAX, 8'h00, 8'h00, 8'h00);

		for (int i = 0; i < RANDOM_LOADS; i++) begin
			steady = ((i / 128) % 4 == 3);
			random_load();
		end
		req_ch.valid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0) $display("tb: clean");
		else $display("tb: errors");
		$finish;
	end

	initial begin
		int  g;
		bit  held;
		held         = 1'b0;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && results_seen >= HOLD_AFTER) begin
				held = 1'b1;
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			g = idle_len((results_seen / 100) % 4 == 2);
			if (g > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
		end
	end

endmodule
